FILE: rtl/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants and helpers for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // screen geometry
    localparam int COLUMNS    = 32;
    localparam int ROWS       = 24;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SCROLL_N   = COLUMNS * (ROWS - 1);
    localparam int COL_LAST   = COLUMNS - 1;
    localparam int ROW_LAST   = ROWS - 1;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // item kinds on the input tuser bit
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // control characters
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7f;

    localparam logic [15:0] CELL_BLANK = 16'h0020;

    // linear cell address of a column and row
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
    endfunction

endpackage

FILE: rtl/text_console_char_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text-cell frame buffer with a cursor; put-char and cell-read items.
// ----------------------------------------------------------------------------
// flow: an item is decoded and handled by the read, char, tab, or mask and
//   newline/backspace states before its result; a scroll copies
//   COLUMNS*(ROWS-1) (736) cells, one per cycle, via the frame memory ports
// throughput: one item at a time, next item accepted from the cycle in which
//   the result is presented
// reset: synchronous active low; a clearing pass zeroes all CELL_COUNT (768)
//   cells of the frame memory, one cell per cycle, while no item is accepted
module text_console_char_writer_top
    import tccw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // char_code[7:0], advance[8], read_index[18:9], zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // kind[0]
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // cursor_x[4:0], cursor_y[9:5], cell_data[25:10], scrolled[26], zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    // state codes
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_RDWAIT = 4'd3;
    localparam logic [3:0] S_MASK   = 4'd4;
    localparam logic [3:0] S_TAB    = 4'd5;
    localparam logic [3:0] S_NL     = 4'd6;
    localparam logic [3:0] S_BS     = 4'd7;
    localparam logic [3:0] S_CHAR   = 4'd8;
    localparam logic [3:0] S_SCROLL = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]           r_state, n_state;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [ADDR_W-1:0]    r_cnt, n_cnt;
    logic                 r_pend, n_pend;
    logic [ADDR_W-1:0]    r_waddr, n_waddr;
    logic                 r_ret_tab, n_ret_tab;
    logic                 r_scrolled, n_scrolled;
    logic [15:0]          r_cell, n_cell;
    logic                 r_kind;
    logic [7:0]           r_char;
    logic                 r_adv;
    logic [9:0]           r_ridx;
    logic                 r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    // frame memory ports
    logic [15:0]       r_mem [CELL_COUNT];
    logic [15:0]       r_rdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;

    logic s_acc;
    logic m_acc;
    logic [ADDR_W-1:0] cur_addr;
    logic col_at_last;
    logic row_at_last;

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign m_acc       = r_out_valid && i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign cur_addr    = cell_addr(r_col, r_row);
    assign col_at_last = (r_col == COL_W'(COL_LAST));
    assign row_at_last = (r_row == ROW_W'(ROW_LAST));

    // frame memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_waddr     = r_waddr;
        n_ret_tab   = r_ret_tab;
        n_scrolled  = r_scrolled;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && !m_acc;
        n_out_data  = r_out_data;
        mem_raddr   = cur_addr;
        mem_we      = 1'b0;
        mem_waddr   = cur_addr;
        mem_wdata   = CELL_BLANK;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = 16'h0000;
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_scrolled = 1'b0;
                    n_cell     = 16'h0000;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_kind == KIND_READ) begin
                    mem_raddr = ADDR_W'(r_ridx);
                    n_state   = S_RDWAIT;
                end else if (r_char == CH_TAB) begin
                    n_state = S_TAB;
                end else if (r_char == CH_LF || r_char == CH_CR ||
                             r_char == CH_BS || r_char == CH_DEL) begin
                    // cursor cell is read for the high-byte clear
                    n_state = S_MASK;
                end else begin
                    n_state = S_CHAR;
                end
            end
            S_RDWAIT: begin
                if (32'(r_ridx) < CELL_COUNT) begin
                    n_cell = r_rdata;
                end
                n_state = S_DONE;
            end
            S_MASK: begin
                mem_we    = 1'b1;
                mem_wdata = {8'h00, r_rdata[7:0]};
                if (r_char == CH_LF || r_char == CH_CR) begin
                    n_state = S_NL;
                end else begin
                    n_state = S_BS;
                end
            end
            S_TAB: begin
                // one blank per cycle, paused while a scroll runs, until the column is 1 mod 4
                mem_we = 1'b1;
                if (col_at_last) begin
                    n_col = '0;
                    if (row_at_last) begin
                        n_scrolled = 1'b1;
                        n_ret_tab  = 1'b1;
                        n_cnt      = '0;
                        n_state    = S_SCROLL;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                    if (r_col[1:0] == 2'd0) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_NL: begin
                n_col = '0;
                if (row_at_last) begin
                    n_scrolled = 1'b1;
                    n_ret_tab  = 1'b0;
                    n_cnt      = '0;
                    n_state    = S_SCROLL;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_BS: begin
                // step back and blank, wrapping to the previous row
                if (r_col != '0) begin
                    n_col     = r_col - 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(r_col - 1'b1, r_row);
                end else if (r_row != '0) begin
                    n_col     = COL_W'(COL_LAST);
                    n_row     = r_row - 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(COL_W'(COL_LAST), r_row - 1'b1);
                end
                n_state = S_DONE;
            end
            S_CHAR: begin
                mem_we    = 1'b1;
                mem_wdata = {8'h00, r_char};
                n_state   = S_DONE;
                if (r_adv) begin
                    if (col_at_last) begin
                        n_state = S_NL;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            S_SCROLL: begin
                // copy pipeline: read cell i+COLUMNS, write it to cell i next cycle
                mem_we    = r_pend;
                mem_waddr = r_waddr;
                mem_wdata = r_rdata;
                mem_raddr = ADDR_W'(r_cnt + ADDR_W'(COLUMNS));
                if (r_cnt == ADDR_W'(SCROLL_N)) begin
                    n_cnt   = '0;
                    n_state = r_ret_tab ? S_TAB : S_DONE;
                end else begin
                    n_pend  = 1'b1;
                    n_waddr = r_cnt;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = M_TDATA_W'({r_scrolled, r_cell, 5'(r_row), 5'(r_col)});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_ret_tab   <= 1'b0;
            r_scrolled  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_ret_tab   <= n_ret_tab;
            r_scrolled  <= n_scrolled;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_waddr    <= n_waddr;
        r_cell     <= n_cell;
        r_out_data <= n_out_data;
        if (s_acc) begin
            r_kind <= i_s_tuser;
            r_char <= i_s_tdata[7:0];
            r_adv  <= i_s_tdata[8];
            r_ridx <= i_s_tdata[18:9];
        end
    end

endmodule

FILE: rtl/tccw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks for the text console character writer, bound to the top.
// ----------------------------------------------------------------------------
module tccw_checker
    import tccw_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [S_TDATA_W-1:0] i_s_tdata,
    input logic                 i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // cursor column stays on the screen
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((COL_LAST >= 31) || (32'(o_m_tdata[4:0]) <= COL_LAST)))
        else $error("cursor column out of range");

    // cursor row stays on the screen
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((ROW_LAST >= 31) || (32'(o_m_tdata[9:5]) <= ROW_LAST)))
        else $error("cursor row out of range");

    // pad bits of the result are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[M_TDATA_W-1:27] == '0))
        else $error("result pad bits not zero");

endmodule

bind text_console_char_writer_top tccw_checker u_tccw_checker (.*);
